>>> src/hsl_pkg.sv
// shared constants and types for the hsl to rgb converter
package hsl_pkg;

    // field widths
    localparam int HUE_W   = 16;
    localparam int Q16_W   = 17;
    localparam int CHAN_W  = 8;
    localparam int PROD_W  = 2 * Q16_W;

    // q1.16 levels
    localparam logic [Q16_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [Q16_W-1:0] HALF_Q16 = 17'd32768;

    // hue breakpoints and channel offsets
    localparam logic [HUE_W-1:0] SIXTH_END  = 16'd10923;
    localparam logic [HUE_W-1:0] HALF_END   = 16'd32768;
    localparam logic [HUE_W-1:0] TWO3_END   = 16'd43691;
    localparam logic [HUE_W-1:0] OFS_RED    = 16'd21845;
    localparam logic [HUE_W-1:0] OFS_GREEN  = 16'd0;
    localparam logic [HUE_W-1:0] OFS_BLUE   = 16'd43691;
    localparam logic [18:0]      FOUR_Q16   = 19'd262144;

    // ramp segment of a hue point
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_ctl;

endpackage

>>> src/hsl_if.sv
// request channel interfaces for hsl input and rgb output

// hsl input channel
interface hsl_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue;
    logic [16:0] saturation;
    logic [16:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

// rgb output channel
interface hsl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> src/hsl_level.sv
// stages one and two: clamp inputs, form the ramp levels m2 and m1
module hsl_level (
    input  logic                              i_clk,
    input  hsl_pkg::t_pipe_ctl                i_ctl,
    input  logic [hsl_pkg::HUE_W-1:0]         i_hue,
    input  logic [hsl_pkg::Q16_W-1:0]         i_sat,
    input  logic [hsl_pkg::Q16_W-1:0]         i_light,
    output logic [hsl_pkg::HUE_W-1:0]         o_hue,
    output logic [hsl_pkg::Q16_W-1:0]         o_m1,
    output logic [hsl_pkg::Q16_W-1:0]         o_m2
);

    logic [hsl_pkg::Q16_W-1:0]  n_sat;
    logic [hsl_pkg::Q16_W-1:0]  n_light;
    logic [hsl_pkg::PROD_W-1:0] n_prod;

    logic [hsl_pkg::HUE_W-1:0]  r_hue1;
    logic [hsl_pkg::Q16_W-1:0]  r_sat;
    logic [hsl_pkg::Q16_W-1:0]  r_light;
    logic [hsl_pkg::PROD_W-1:0] r_prod;

    logic [hsl_pkg::Q16_W-1:0]  n_q;
    logic [hsl_pkg::Q16_W:0]    n_m2_raw;
    logic [hsl_pkg::Q16_W-1:0]  n_m2;
    logic [hsl_pkg::Q16_W:0]    n_two_l;
    logic [hsl_pkg::Q16_W:0]    n_m1_raw;
    logic [hsl_pkg::Q16_W-1:0]  n_m1;

    logic [hsl_pkg::HUE_W-1:0]  r_hue2;
    logic [hsl_pkg::Q16_W-1:0]  r_m1;
    logic [hsl_pkg::Q16_W-1:0]  r_m2;

    // saturate to one and multiply
    always_comb begin
        n_sat   = (i_sat > hsl_pkg::ONE_Q16) ? hsl_pkg::ONE_Q16 : i_sat;
        n_light = (i_light > hsl_pkg::ONE_Q16) ? hsl_pkg::ONE_Q16 : i_light;
        n_prod  = n_light * n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1) begin
            r_hue1  <= i_hue;
            r_sat   <= n_sat;
            r_light <= n_light;
            r_prod  <= n_prod;
        end
    end

    // m2 from l*s, then m1 = 2l - m2 kept within [0, m2]
    always_comb begin
        n_q = r_prod[hsl_pkg::PROD_W-2:16];
        if (r_light <= hsl_pkg::HALF_Q16) begin
            n_m2_raw = {1'b0, r_light} + {1'b0, n_q};
        end else begin
            n_m2_raw = {1'b0, r_light} + {1'b0, r_sat} - {1'b0, n_q};
        end
        n_m2 = (n_m2_raw > {1'b0, hsl_pkg::ONE_Q16}) ? hsl_pkg::ONE_Q16
                                                     : n_m2_raw[hsl_pkg::Q16_W-1:0];
        n_two_l  = {r_light, 1'b0};
        n_m1_raw = (n_two_l >= {1'b0, n_m2}) ? (n_two_l - {1'b0, n_m2}) : '0;
        n_m1 = (n_m1_raw > {1'b0, n_m2}) ? n_m2 : n_m1_raw[hsl_pkg::Q16_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2) begin
            r_hue2 <= r_hue1;
            r_m1   <= n_m1;
            r_m2   <= n_m2;
        end
    end

    assign o_hue = r_hue2;
    assign o_m1  = r_m1;
    assign o_m2  = r_m2;

endmodule

>>> src/hsl_ramp.sv
// stages three to five: hue ramp of one channel and scaling to a byte
module hsl_ramp (
    input  logic                              i_clk,
    input  hsl_pkg::t_pipe_ctl                i_ctl,
    input  logic [hsl_pkg::HUE_W-1:0]         i_hue,
    input  logic [hsl_pkg::HUE_W-1:0]         i_ofs,
    input  logic [hsl_pkg::Q16_W-1:0]         i_m1,
    input  logic [hsl_pkg::Q16_W-1:0]         i_m2,
    output logic [hsl_pkg::CHAN_W-1:0]        o_chan
);

    logic [hsl_pkg::HUE_W-1:0]  n_x;
    logic [18:0]                n_six_x;
    logic [18:0]                n_k_wide;
    hsl_pkg::t_seg              n_seg;
    logic [hsl_pkg::Q16_W-1:0]  n_k;

    hsl_pkg::t_seg              r_seg3;
    logic [hsl_pkg::Q16_W-1:0]  r_k;
    logic [hsl_pkg::Q16_W-1:0]  r_d;
    logic [hsl_pkg::Q16_W-1:0]  r_m1_3;
    logic [hsl_pkg::Q16_W-1:0]  r_m2_3;

    logic [hsl_pkg::PROD_W-1:0] n_prod;

    hsl_pkg::t_seg              r_seg4;
    logic [hsl_pkg::Q16_W-1:0]  r_q;
    logic [hsl_pkg::Q16_W-1:0]  r_m1_4;
    logic [hsl_pkg::Q16_W-1:0]  r_m2_4;

    logic [hsl_pkg::Q16_W:0]    n_v_raw;
    logic [hsl_pkg::Q16_W-1:0]  n_v;
    logic [24:0]                n_scaled;
    logic [hsl_pkg::CHAN_W-1:0] r_chan;

    // hue point, segment and slope factor
    always_comb begin
        n_x      = i_hue + i_ofs;
        n_six_x  = {3'b000, n_x} * 19'd6;
        n_k_wide = '0;
        if (n_x < hsl_pkg::SIXTH_END) begin
            n_seg    = hsl_pkg::SEG_RISE;
            n_k_wide = n_six_x;
        end else if (n_x < hsl_pkg::HALF_END) begin
            n_seg    = hsl_pkg::SEG_HIGH;
        end else if (n_x < hsl_pkg::TWO3_END) begin
            n_seg    = hsl_pkg::SEG_FALL;
            n_k_wide = hsl_pkg::FOUR_Q16 - n_six_x;
        end else begin
            n_seg    = hsl_pkg::SEG_LOW;
        end
        n_k = n_k_wide[hsl_pkg::Q16_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3) begin
            r_seg3 <= n_seg;
            r_k    <= n_k;
            r_d    <= i_m2 - i_m1;
            r_m1_3 <= i_m1;
            r_m2_3 <= i_m2;
        end
    end

    // slope times span
    assign n_prod = r_d * r_k;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s4) begin
            r_seg4 <= r_seg3;
            r_q    <= n_prod[hsl_pkg::PROD_W-2:16];
            r_m1_4 <= r_m1_3;
            r_m2_4 <= r_m2_3;
        end
    end

    // pick segment value, clamp to one, times 255
    always_comb begin
        case (r_seg4) inside
            hsl_pkg::SEG_RISE,
            hsl_pkg::SEG_FALL: n_v_raw = {1'b0, r_m1_4} + {1'b0, r_q};
            hsl_pkg::SEG_HIGH: n_v_raw = {1'b0, r_m2_4};
            default:           n_v_raw = {1'b0, r_m1_4};
        endcase
        n_v = (n_v_raw > {1'b0, hsl_pkg::ONE_Q16}) ? hsl_pkg::ONE_Q16
                                                   : n_v_raw[hsl_pkg::Q16_W-1:0];
        n_scaled = {n_v, 8'h00} - {8'h00, n_v};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s5) begin
            r_chan <= n_scaled[23:16];
        end
    end

    assign o_chan = r_chan;

endmodule

>>> src/hsl_to_rgb_converter.sv
// top level of the hsl to rgb converter: pipeline control and channel ramps
//
// Takes one hsl request on i_in (hue as a 16-bit fraction of a turn,
// saturation and lightness in unsigned q1.16, saturating at one) and
// returns one rgb request on o_out with 8-bit red, green and blue.
// Both channels use valid/ready; a request moves when both are high.
//
// Five register stages: input clamp and l*s product, ramp levels m1/m2,
// hue points and slopes, slope multiply, segment pick and byte scaling.
// Throughput is one request per cycle while o_out.ready is high; the
// per-channel 17x17 multipliers are fully pipelined, so nothing iterates.
//
// Reset clears the stage valid bits only; the pipeline is empty after it.
// When the receiver holds o_out.ready low, each stage keeps its request
// until the stage after it frees up; i_in.ready drops once all five stages
// are full, and no request is lost or repeated.
module hsl_to_rgb_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsl_in_if.sink     i_in,
    hsl_out_if.source  o_out
);

    logic [4:0]          r_valid;
    hsl_pkg::t_pipe_ctl  pipe_ctl;

    logic [hsl_pkg::HUE_W-1:0] lvl_hue;
    logic [hsl_pkg::Q16_W-1:0] lvl_m1;
    logic [hsl_pkg::Q16_W-1:0] lvl_m2;

    // stage loads back to front
    always_comb begin
        pipe_ctl.s5 = !r_valid[4] || o_out.ready;
        pipe_ctl.s4 = !r_valid[3] || pipe_ctl.s5;
        pipe_ctl.s3 = !r_valid[2] || pipe_ctl.s4;
        pipe_ctl.s2 = !r_valid[1] || pipe_ctl.s3;
        pipe_ctl.s1 = !r_valid[0] || pipe_ctl.s2;
    end

    assign i_in.ready  = pipe_ctl.s1;
    assign o_out.valid = r_valid[4];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (pipe_ctl.s1) r_valid[0] <= i_in.valid;
            if (pipe_ctl.s2) r_valid[1] <= r_valid[0];
            if (pipe_ctl.s3) r_valid[2] <= r_valid[1];
            if (pipe_ctl.s4) r_valid[3] <= r_valid[2];
            if (pipe_ctl.s5) r_valid[4] <= r_valid[3];
        end
    end

    // ramp levels
    hsl_level u_level (
        .i_clk   (i_clk),
        .i_ctl   (pipe_ctl),
        .i_hue   (i_in.hue),
        .i_sat   (i_in.saturation),
        .i_light (i_in.lightness),
        .o_hue   (lvl_hue),
        .o_m1    (lvl_m1),
        .o_m2    (lvl_m2)
    );

    // red at hue plus a third
    hsl_ramp u_ramp_red (
        .i_clk  (i_clk),
        .i_ctl  (pipe_ctl),
        .i_hue  (lvl_hue),
        .i_ofs  (hsl_pkg::OFS_RED),
        .i_m1   (lvl_m1),
        .i_m2   (lvl_m2),
        .o_chan (o_out.red)
    );

    // green at hue
    hsl_ramp u_ramp_green (
        .i_clk  (i_clk),
        .i_ctl  (pipe_ctl),
        .i_hue  (lvl_hue),
        .i_ofs  (hsl_pkg::OFS_GREEN),
        .i_m1   (lvl_m1),
        .i_m2   (lvl_m2),
        .o_chan (o_out.green)
    );

    // blue at hue minus a third
    hsl_ramp u_ramp_blue (
        .i_clk  (i_clk),
        .i_ctl  (pipe_ctl),
        .i_hue  (lvl_hue),
        .i_ofs  (hsl_pkg::OFS_BLUE),
        .i_m1   (lvl_m1),
        .i_m2   (lvl_m2),
        .o_chan (o_out.blue)
    );

`ifndef SYNTHESIS
    // an accepted request occupies the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_valid[0])
        else $error("accepted request missing from first stage");

    // a blocked middle stage keeps its request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[2] && !pipe_ctl.s4 |=> r_valid[2])
        else $error("stalled request dropped in stage three");

    // a request leaving stage four reaches the output
    a_reach_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[3] && pipe_ctl.s5 |=> o_out.valid)
        else $error("request lost before output");

    // a full pipeline with a stalled receiver refuses input
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_valid) && !o_out.ready |-> !i_in.ready)
        else $error("input accepted into a full pipeline");
`endif

endmodule

>>> sim/tb_hsl_to_rgb_converter.sv
// testbench for the hsl to rgb converter: random and corner requests against a built-in predictor
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter;

    // predictor constants, kept apart from the design's own
    localparam bit [16:0] Q_ONE       = 17'd65536;
    localparam bit [16:0] Q_HALF      = 17'd32768;
    localparam bit [15:0] RISE_END    = 16'd10923;
    localparam bit [15:0] HIGH_END    = 16'd32768;
    localparam bit [15:0] FALL_END    = 16'd43691;
    localparam bit [15:0] THIRD_TURN  = 16'd21845;
    localparam int        RANDOM_REQS = 550;
    localparam int        CYCLE_LIMIT = 200000;
    localparam int        IDLE_PCT    = 32;
    localparam int        HOLD_START  = 300;
    localparam int        HOLD_LEN    = 80;
    localparam int        DRAIN_WAIT  = 20;

    typedef struct packed {
        bit [15:0] hue;
        bit [16:0] sat;
        bit [16:0] light;
    } t_hsl_req;

    typedef struct packed {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
    } t_rgb_px;

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt = 0;
    int   fault_cnt = 0;
    int   hold_left = 0;
    logic quiet_span;

    t_hsl_req hsl_backlog[$];
    t_rgb_px  rgb_due[$];
    t_hsl_req next_req;
    t_rgb_px  want_px;

    hsl_in_if  in_ch ();
    hsl_out_if out_ch ();

    hsl_to_rgb_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // clamp a q1.16 level to one
    function automatic bit [16:0] clamp_q16(bit [17:0] v);
        return (v > {1'b0, Q_ONE}) ? Q_ONE : v[16:0];
    endfunction

    // ramp value at hue point x between lo and hi, scaled to a byte
    function automatic bit [7:0] ramp_byte(bit [15:0] x, bit [16:0] lo, bit [16:0] hi);
        bit [16:0]     span;
        bit [35:0]     prod;
        bit [17:0]     level;
        bit [24:0]     scaled;
        hsl_pkg::t_seg seg;
        span = hi - lo;
        if (x < RISE_END)
            seg = hsl_pkg::SEG_RISE;
        else if (x < HIGH_END)
            seg = hsl_pkg::SEG_HIGH;
        else if (x < FALL_END)
            seg = hsl_pkg::SEG_FALL;
        else
            seg = hsl_pkg::SEG_LOW;
        prod  = '0;
        level = '0;
        case (seg)
            hsl_pkg::SEG_RISE: begin
                prod  = span * (36'd6 * x);
                level = lo + prod[33:16];
            end
            hsl_pkg::SEG_HIGH: begin
                level = hi;
            end
            hsl_pkg::SEG_FALL: begin
                prod  = span * (36'd262144 - 36'd6 * x);
                level = lo + prod[33:16];
            end
            default: begin
                level = lo;
            end
        endcase
        scaled = clamp_q16(level) * 25'd255;
        return scaled[23:16];
    endfunction

    // full conversion of one request
    function automatic t_rgb_px hsl_to_rgb(t_hsl_req req);
        bit [16:0] s;
        bit [16:0] l;
        bit [35:0] prod;
        bit [17:0] sum;
        bit [17:0] twice_l;
        bit [16:0] m2;
        bit [16:0] m1;
        bit [15:0] red_x;
        bit [15:0] blue_x;
        t_rgb_px   px;
        s = clamp_q16({1'b0, req.sat});
        l = clamp_q16({1'b0, req.light});
        if (l <= Q_HALF) begin
            prod = l * (36'd65536 + s);
            m2   = clamp_q16(prod[33:16]);
        end else begin
            prod = l * s;
            sum  = {1'b0, l} + {1'b0, s} - prod[33:16];
            m2   = clamp_q16(sum);
        end
        twice_l = {l, 1'b0};
        m1      = (twice_l >= {1'b0, m2}) ? clamp_q16(twice_l - {1'b0, m2}) : 17'd0;
        if (m1 > m2)
            m1 = m2;
        red_x    = req.hue + THIRD_TURN;
        blue_x   = req.hue - THIRD_TURN;
        px.red   = ramp_byte(red_x, m1, m2);
        px.green = ramp_byte(req.hue, m1, m2);
        px.blue  = ramp_byte(blue_x, m1, m2);
        return px;
    endfunction

    // random saturation or lightness, mostly in range, some over one, some corners
    function automatic bit [16:0] pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 17'($urandom_range(65536));
        else if (r < 70)
            return 17'($urandom_range(131071, 65537));
        else if (r < 85)
            return 17'($urandom);
        case ($urandom_range(4))
            0: return 17'd0;
            1: return Q_HALF;
            2: return Q_HALF + 17'd1;
            3: return Q_ONE;
            default: return 17'd131071;
        endcase
    endfunction

    // random hue, some on the ramp breakpoints and wrap points
    function automatic bit [15:0] pick_hue();
        bit [15:0] marks [12];
        marks = '{16'd0, 16'd65535, 16'd10922, 16'd10923, 16'd32767, 16'd32768,
                  16'd43690, 16'd43691, 16'd21844, 16'd21845, 16'd54613, 16'd54614};
        if ($urandom_range(99) < 85)
            return 16'($urandom);
        return marks[$urandom_range(11)];
    endfunction

    task automatic add_req(bit [15:0] h, bit [16:0] s, bit [16:0] l);
        t_hsl_req req;
        req.hue   = h;
        req.sat   = s;
        req.light = l;
        hsl_backlog.push_back(req);
    endtask

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // free-running cycle count and run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // window where neither side idles
    assign quiet_span = (cycle_cnt >= 600) && (cycle_cnt < 900);

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (hsl_backlog.size() > 0 && (quiet_span || $urandom_range(99) >= IDLE_PCT)) begin
                next_req         = hsl_backlog.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.hue        <= next_req.hue;
                in_ch.saturation <= next_req.sat;
                in_ch.lightness  <= next_req.light;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off to fill the pipeline
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (cycle_cnt == HOLD_START) begin
            hold_left    <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= quiet_span || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // check results first, then predict for the request taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (rgb_due.size() == 0) begin
                    $display("%0t: unexpected rgb %0d/%0d/%0d", $time,
                             out_ch.red, out_ch.green, out_ch.blue);
                    fault_cnt = fault_cnt + 1;
                end else begin
                    want_px = rgb_due.pop_front();
                    if (out_ch.red !== want_px.red || out_ch.green !== want_px.green ||
                        out_ch.blue !== want_px.blue) begin
                        $display("%0t: rgb expected %0d/%0d/%0d got %0d/%0d/%0d", $time,
                                 want_px.red, want_px.green, want_px.blue,
                                 out_ch.red, out_ch.green, out_ch.blue);
                        fault_cnt = fault_cnt + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                rgb_due.push_back(hsl_to_rgb({in_ch.hue, in_ch.saturation, in_ch.lightness}));
        end
    end

    // stimulus, reset and final verdict
    initial begin
        i_rst_n = 1'b0;

        // directed: field extremes, breakpoints, hue wrap, clamping, white and black
        add_req(16'd0,     17'd0,      17'd0);
        add_req(16'd65535, 17'd131071, 17'd131071);
        add_req(16'd0,     17'd65536,  17'd32768);
        add_req(16'd65535, 17'd65536,  17'd32768);
        add_req(16'd10922, 17'd65536,  17'd32768);
        add_req(16'd10923, 17'd65536,  17'd32768);
        add_req(16'd32767, 17'd65536,  17'd32768);
        add_req(16'd32768, 17'd65536,  17'd32768);
        add_req(16'd43690, 17'd65536,  17'd32768);
        add_req(16'd43691, 17'd65536,  17'd32768);
        add_req(16'd21844, 17'd40000,  17'd20000);
        add_req(16'd21845, 17'd40000,  17'd20000);
        add_req(16'd54613, 17'd40000,  17'd50000);
        add_req(16'd54614, 17'd40000,  17'd50000);
        add_req(16'd12345, 17'd131071, 17'd30000);
        add_req(16'd40000, 17'd65537,  17'd45000);
        add_req(16'd5000,  17'd50000,  17'd131071);
        add_req(16'd5000,  17'd50000,  17'd65537);
        add_req(16'd5000,  17'd50000,  17'd65536);
        add_req(16'd30000, 17'd0,      17'd40000);
        add_req(16'd30000, 17'd65536,  17'd32769);
        add_req(16'd60000, 17'd1,      17'd1);
        add_req(16'd2000,  17'd98304,  17'd98304);

        for (int i = 0; i < RANDOM_REQS; i++)
            add_req(pick_hue(), pick_level(), pick_level());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (hsl_backlog.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        while (rgb_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fault_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
